@@ rtl/core/odm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// odm_pkg
// shared types and constants for the omni drive mixer with heading hold
// ----------------------------------------------------------------------------
package odm_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    // register indexes on the config port
    localparam logic [CFG_INDEX_W-1:0] CFG_REF_HEADING = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DRIVE_SPEED = 1'd1;

    localparam int NUM_WHEELS = 4;
    localparam int NUM_DIRS   = 17;
    localparam logic [4:0] DIR_STOP = 5'd16;

    localparam logic OP_TABLE    = 1'b0;
    localparam logic OP_EXPLICIT = 1'b1;

    // direction table codes: magnitude full or half, sign gives direction
    localparam logic signed [2:0] CODE_FULL     = 3'sd2;
    localparam logic signed [2:0] CODE_HALF     = 3'sd1;
    localparam logic signed [2:0] CODE_NEG_HALF = -3'sd1;
    localparam logic signed [2:0] CODE_NEG_FULL = -3'sd2;

    localparam logic signed [2:0] DIR_TABLE [NUM_DIRS][NUM_WHEELS] = '{
        '{ 3'sd2,  3'sd2, -3'sd2, -3'sd2}, '{ 3'sd2,  3'sd1, -3'sd2, -3'sd1},
        '{ 3'sd2,  3'sd0, -3'sd2,  3'sd0}, '{ 3'sd2, -3'sd1, -3'sd2,  3'sd1},
        '{ 3'sd2, -3'sd2, -3'sd2,  3'sd2}, '{ 3'sd1, -3'sd2, -3'sd1,  3'sd2},
        '{ 3'sd0, -3'sd2,  3'sd0,  3'sd2}, '{-3'sd1, -3'sd2,  3'sd1,  3'sd2},
        '{-3'sd2, -3'sd2,  3'sd2,  3'sd2}, '{-3'sd2, -3'sd1,  3'sd2,  3'sd1},
        '{-3'sd2,  3'sd0,  3'sd2,  3'sd0}, '{-3'sd2,  3'sd1,  3'sd2, -3'sd1},
        '{-3'sd2,  3'sd2,  3'sd2, -3'sd2}, '{-3'sd1,  3'sd2,  3'sd1, -3'sd2},
        '{ 3'sd0,  3'sd2,  3'sd0, -3'sd2}, '{ 3'sd1,  3'sd2, -3'sd1, -3'sd2},
        '{ 3'sd0,  3'sd0,  3'sd0,  3'sd0}
    };

    // heading correction constants
    localparam logic signed [9:0]  WRAP_HIGH = 10'sd128;
    localparam logic signed [9:0]  WRAP_LOW  = -10'sd128;
    localparam logic signed [9:0]  WRAP_SPAN = 10'sd256;
    localparam logic signed [8:0]  FINE_BAND = 9'sd25;
    localparam logic signed [12:0] WHEEL_MAX = 13'sd255;
    localparam logic signed [12:0] WHEEL_MIN = -13'sd255;

    typedef struct packed {
        logic               opcode;
        logic [4:0]         direction;
        logic [7:0]         compass_reading;
        logic signed [11:0] left_one_cmd;
        logic signed [11:0] left_two_cmd;
        logic signed [11:0] right_two_cmd;
        logic signed [11:0] right_one_cmd;
    } t_in_word;

    typedef struct packed {
        logic [7:0] left_one_duty;
        logic       left_one_rev;
        logic [7:0] left_two_duty;
        logic       left_two_rev;
        logic [7:0] right_two_duty;
        logic       right_two_rev;
        logic [7:0] right_one_duty;
        logic       right_one_rev;
    } t_out_word;

endpackage
`default_nettype wire

@@ rtl/core/omni_drive_mixer_heading_hold.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// omni_drive_mixer_heading_hold
// mixes a drive request and a compass byte into four wheel pwm settings
// ----------------------------------------------------------------------------
//
//  channel   signals                           direction  carries
//  -------   --------------------------------  ---------  ----------------------
//  in        i_in_valid o_in_ready i_in_word    in         drive request + compass
//  out       o_out_valid i_out_ready o_out_word out        four duty/rev pairs
//  cfg       i_cfg_we i_cfg_index i_cfg_data    in         heading ref, speed
//
//  one word per cycle sustained while the output accepts words; a word that is taken
//  passes through capture, correction, sum/clamp and the output register in order
//  each stage holds its own valid bit and moves when the stage after it is
//  empty or moving, so bubbles close up behind a stalled output
//  a table request with direction above stop is taken and dropped
//  i_rst_n is synchronous: it empties the pipe and loads the register defaults
//
module omni_drive_mixer_heading_hold (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,

    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire odm_pkg::t_in_word             i_in_word,

    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output odm_pkg::t_out_word                 o_out_word,

    input  wire logic                          i_cfg_we,
    input  wire logic [odm_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [odm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import odm_pkg::*;

    // configuration registers
    logic [7:0] r_ref_heading;
    logic [7:0] r_drive_speed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_heading <= 8'd0;
            r_drive_speed <= 8'd255;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_REF_HEADING: r_ref_heading <= i_cfg_data;
                CFG_DRIVE_SPEED: r_drive_speed <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage valid bits and per-stage advance
    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4 = !r_v4 || i_out_ready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign o_in_ready = rdy1;

    // ---------------------------------------------------------------- stage 1
    // pick wheel base values, wrap the heading error into -128..128
    logic                keep_word;
    logic [4:0]          dir_row;
    logic [7:0]          half_speed;
    logic signed [11:0]  n_wheel [NUM_WHEELS];
    logic signed [11:0]  cmd     [NUM_WHEELS];
    logic signed [9:0]   raw_err;
    logic signed [9:0]   wrap_err;
    logic signed [2:0]   code;

    assign keep_word  = (i_in_word.opcode == OP_EXPLICIT) || (i_in_word.direction <= DIR_STOP);
    assign dir_row    = (i_in_word.direction <= DIR_STOP) ? i_in_word.direction : DIR_STOP;
    assign half_speed = r_drive_speed >> 1;

    assign cmd[0] = i_in_word.left_one_cmd;
    assign cmd[1] = i_in_word.left_two_cmd;
    assign cmd[2] = i_in_word.right_two_cmd;
    assign cmd[3] = i_in_word.right_one_cmd;

    always_comb begin
        for (int k = 0; k < NUM_WHEELS; k++) begin
            code = DIR_TABLE[dir_row][k];
            if (i_in_word.opcode == OP_EXPLICIT) begin
                n_wheel[k] = cmd[k];
            end else begin
                unique case (code)
                    CODE_FULL:     n_wheel[k] = $signed({4'd0, r_drive_speed});
                    CODE_HALF:     n_wheel[k] = $signed({4'd0, half_speed});
                    CODE_NEG_HALF: n_wheel[k] = -$signed({4'd0, half_speed});
                    CODE_NEG_FULL: n_wheel[k] = -$signed({4'd0, r_drive_speed});
                    default:       n_wheel[k] = 12'sd0;
                endcase
            end
        end
    end

    assign raw_err = $signed({2'b00, i_in_word.compass_reading})
                   - $signed({2'b00, r_ref_heading});

    always_comb begin
        if (raw_err > WRAP_HIGH) begin
            wrap_err = raw_err - WRAP_SPAN;
        end else if (raw_err < WRAP_LOW) begin
            wrap_err = raw_err + WRAP_SPAN;
        end else begin
            wrap_err = raw_err;
        end
    end

    logic signed [11:0] r_s1_wheel [NUM_WHEELS];
    logic signed [8:0]  r_s1_err;

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_wheel <= n_wheel;
            r_s1_err   <= wrap_err[8:0];
        end
    end

    // ---------------------------------------------------------------- stage 2
    // gain -3 inside the fine band, -2 outside
    logic signed [10:0] err_x;
    logic signed [10:0] n_corr;

    assign err_x = {{2{r_s1_err[8]}}, r_s1_err};

    always_comb begin
        if ((r_s1_err <= FINE_BAND) && (r_s1_err >= -FINE_BAND)) begin
            n_corr = -(err_x + (err_x <<< 1));
        end else begin
            n_corr = -(err_x <<< 1);
        end
    end

    logic signed [11:0] r_s2_wheel [NUM_WHEELS];
    logic signed [9:0]  r_s2_corr;

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_s2_wheel <= r_s1_wheel;
            r_s2_corr  <= n_corr[9:0];
        end
    end

    // ---------------------------------------------------------------- stage 3
    // add correction to each wheel and clamp to +-255
    logic signed [12:0] wsum  [NUM_WHEELS];
    logic signed [8:0]  n_clp [NUM_WHEELS];

    always_comb begin
        for (int k = 0; k < NUM_WHEELS; k++) begin
            wsum[k] = {r_s2_wheel[k][11], r_s2_wheel[k]}
                    + {{3{r_s2_corr[9]}}, r_s2_corr};
            if (wsum[k] > WHEEL_MAX) begin
                n_clp[k] = WHEEL_MAX[8:0];
            end else if (wsum[k] < WHEEL_MIN) begin
                n_clp[k] = WHEEL_MIN[8:0];
            end else begin
                n_clp[k] = wsum[k][8:0];
            end
        end
    end

    logic signed [8:0] r_s3_clp [NUM_WHEELS];

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_s3_clp <= n_clp;
        end
    end

    // ---------------------------------------------------------------- stage 4
    // positive value drives forward at that duty, else reverse at 255+v
    logic [7:0] duty [NUM_WHEELS];
    logic       rev  [NUM_WHEELS];
    logic [8:0] off_sum [NUM_WHEELS];
    t_out_word  n_out;

    always_comb begin
        for (int k = 0; k < NUM_WHEELS; k++) begin
            off_sum[k] = r_s3_clp[k] + 9'd255;
            if (r_s3_clp[k] > 9'sd0) begin
                duty[k] = r_s3_clp[k][7:0];
                rev[k]  = 1'b0;
            end else begin
                duty[k] = off_sum[k][7:0];
                rev[k]  = 1'b1;
            end
        end
        n_out.left_one_duty  = duty[0];
        n_out.left_one_rev   = rev[0];
        n_out.left_two_duty  = duty[1];
        n_out.left_two_rev   = rev[1];
        n_out.right_two_duty = duty[2];
        n_out.right_two_rev  = rev[2];
        n_out.right_one_duty = duty[3];
        n_out.right_one_rev  = rev[3];
    end

    t_out_word r_out;

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_out <= n_out;
        end
    end

    // valid bits follow their data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_in_valid && keep_word;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    assign o_out_valid = r_v4;
    assign o_out_word  = r_out;

endmodule
`default_nettype wire
